@@ rtl/hsv_pkg.sv @@
// hsv_pkg: shared constants and types for the HSV to RGB converter.
// No dependencies; imported by hsv_to_rgb_converter.
package hsv_pkg;

  // Default number of fraction bits for saturation, brightness and channels
  localparam int FRAC_BITS_DEF = 16;

  // Hue is a Q16 fraction of one turn
  localparam int HUE_BITS = 16;

  // Field and packed stream widths (the stream widths are whole bytes)
  localparam int SAT_BITS      = 17;
  localparam int BRI_BITS      = 17;
  localparam int IN_DATA_BITS  = 56;
  localparam int CHAN_BITS     = 8;
  localparam int OUT_DATA_BITS = 24;

  // Color wheel sector, hue times six; order of (red, green, blue)
  typedef enum logic [2:0] {
    SEC_VNM = 3'd0,  // red max, green rising
    SEC_NVM = 3'd1,  // green max, red falling
    SEC_MVN = 3'd2,  // green max, blue rising
    SEC_MNV = 3'd3,  // blue max, green falling
    SEC_NMV = 3'd4,  // blue max, red rising
    SEC_VMN = 3'd5   // red max, blue falling
  } sector_t;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// Throughput: one color per cycle while out_tready does not stall; four register stages (clamp and sector,
//   v*(1-s) and s*f multiplies, v*(1-s*f) multiply, channel select and scale).
// A stall on out_tready holds each full stage whose later stages are all full; empty stages keep filling.
// Reset: rst_n synchronous, active low, clears all stage valid bits; data is not reset.
// Depends on hsv_pkg.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: hue [15:0], saturation [32:16], brightness [49:33], zero pad [55:50]
  input  logic [55:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: red [7:0], green [15:8], blue [23:16]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready
);
  import hsv_pkg::*;

  // Internal fraction width holds 0..ONE; compare width covers the raw input
  localparam int VW = FRAC_BITS + 1;
  localparam int CW = (VW > SAT_BITS) ? VW : SAT_BITS;
  localparam int FW = HUE_BITS + 1;
  localparam logic [VW-1:0] ONE_VW = VW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] ONE_CW = CW'(1) << FRAC_BITS;
  localparam logic [FW-1:0] HUE_ONE = FW'(1) << HUE_BITS;

  // Channel scale: floor(x * 255 / ONE), done as (x << 8) - x
  function automatic logic [CHAN_BITS-1:0] to_byte(input logic [VW-1:0] x);
    logic [VW+7:0] prod;
    prod = ({x, 8'b0}) - (VW+8)'(x);
    return prod[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // Stage handshake: a stage loads when it is empty or its contents move on
  logic out_vld_r, s3_vld_r, s2_vld_r, s1_vld_r;
  logic out_en, s3_en, s2_en, s1_en;

  assign out_en    = !out_vld_r || out_tready;
  assign s3_en     = !s3_vld_r || out_en;
  assign s2_en     = !s2_vld_r || s3_en;
  assign s1_en     = !s1_vld_r || s2_en;
  assign in_tready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_en)  s1_vld_r  <= in_tvalid;
      if (s2_en)  s2_vld_r  <= s1_vld_r;
      if (s3_en)  s3_vld_r  <= s2_vld_r;
      if (out_en) out_vld_r <= s3_vld_r;
    end
  end

  // ---------------- Stage 1: clamp, sector and hue fraction ----------------
  logic [HUE_BITS-1:0] hue;
  logic [SAT_BITS-1:0] sat_in;
  logic [BRI_BITS-1:0] bri_in;
  logic [CW-1:0]       sat_ext, bri_ext;
  logic [HUE_BITS+2:0] hue6;
  logic [HUE_BITS-1:0] frac_raw;
  sector_t             sec_nxt;
  logic [FW-1:0]       f_nxt;
  logic [VW-1:0]       s_nxt, v1_nxt;

  assign hue     = in_tdata[HUE_BITS-1:0];
  assign sat_in  = in_tdata[HUE_BITS+SAT_BITS-1:HUE_BITS];
  assign bri_in  = in_tdata[HUE_BITS+SAT_BITS+BRI_BITS-1:HUE_BITS+SAT_BITS];
  assign sat_ext = CW'(sat_in);
  assign bri_ext = CW'(bri_in);

  // hue * 6 = (hue << 2) + (hue << 1)
  assign hue6     = ({3'b0, hue} << 2) + ({3'b0, hue} << 1);
  assign frac_raw = hue6[HUE_BITS-1:0];
  assign sec_nxt  = sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
  // Even sectors use the inverted fraction
  assign f_nxt    = hue6[HUE_BITS] ? FW'(frac_raw) : (HUE_ONE - FW'(frac_raw));
  assign s_nxt    = (sat_ext > ONE_CW) ? ONE_VW : sat_ext[VW-1:0];
  assign v1_nxt   = (bri_ext > ONE_CW) ? ONE_VW : bri_ext[VW-1:0];

  sector_t       s1_sec_r;
  logic [FW-1:0] s1_f_r;
  logic [VW-1:0] s1_s_r, s1_v_r;

  always_ff @(posedge clk) begin
    if (s1_en && in_tvalid) begin
      s1_sec_r <= sec_nxt;
      s1_f_r   <= f_nxt;
      s1_s_r   <= s_nxt;
      s1_v_r   <= v1_nxt;
    end
  end

  // ---------------- Stage 2: m = v(1-s), sf = s*f ----------------
  logic [VW+FW-1:0] sf_prod;
  logic [VW:0]      sf_shift;
  logic [VW-1:0]    sf_nxt, m_nxt;
  logic [2*VW-1:0]  m_prod;

  assign sf_prod  = (VW+FW)'(s1_s_r) * (VW+FW)'(s1_f_r);
  assign sf_shift = sf_prod[VW+FW-1:HUE_BITS];
  assign sf_nxt   = (sf_shift > {1'b0, ONE_VW}) ? ONE_VW : sf_shift[VW-1:0];
  assign m_prod   = (2*VW)'(s1_v_r) * (2*VW)'(ONE_VW - s1_s_r);
  assign m_nxt    = m_prod[FRAC_BITS+VW-1:FRAC_BITS];

  sector_t       s2_sec_r;
  logic [VW-1:0] s2_sf_r, s2_m_r, s2_v_r;

  always_ff @(posedge clk) begin
    if (s2_en && s1_vld_r) begin
      s2_sec_r <= s1_sec_r;
      s2_sf_r  <= sf_nxt;
      s2_m_r   <= m_nxt;
      s2_v_r   <= s1_v_r;
    end
  end

  // ---------------- Stage 3: n = v(1-sf) ----------------
  logic [2*VW-1:0] n_prod;
  logic [VW-1:0]   n_nxt;

  assign n_prod = (2*VW)'(s2_v_r) * (2*VW)'(ONE_VW - s2_sf_r);
  assign n_nxt  = n_prod[FRAC_BITS+VW-1:FRAC_BITS];

  sector_t       s3_sec_r;
  logic [VW-1:0] s3_n_r, s3_m_r, s3_v_r;

  always_ff @(posedge clk) begin
    if (s3_en && s2_vld_r) begin
      s3_sec_r <= s2_sec_r;
      s3_n_r   <= n_nxt;
      s3_m_r   <= s2_m_r;
      s3_v_r   <= s2_v_r;
    end
  end

  // ---------------- Stage 4: channel order and scale to bytes ----------------
  logic [VW-1:0]             r_sel, g_sel, b_sel;
  logic [OUT_DATA_BITS-1:0]  out_nxt;
  logic [OUT_DATA_BITS-1:0]  out_data_r;

  always_comb begin
    unique case (s3_sec_r)
      SEC_VNM: begin r_sel = s3_v_r; g_sel = s3_n_r; b_sel = s3_m_r; end
      SEC_NVM: begin r_sel = s3_n_r; g_sel = s3_v_r; b_sel = s3_m_r; end
      SEC_MVN: begin r_sel = s3_m_r; g_sel = s3_v_r; b_sel = s3_n_r; end
      SEC_MNV: begin r_sel = s3_m_r; g_sel = s3_n_r; b_sel = s3_v_r; end
      SEC_NMV: begin r_sel = s3_n_r; g_sel = s3_m_r; b_sel = s3_v_r; end
      default: begin r_sel = s3_v_r; g_sel = s3_m_r; b_sel = s3_n_r; end
    endcase
  end

  assign out_nxt = {to_byte(b_sel), to_byte(g_sel), to_byte(r_sel)};

  always_ff @(posedge clk) begin
    if (out_en && s3_vld_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_vld_r;

`ifndef SYNTHESIS
  // An accepted transfer always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_vld_r)
    else $error("accepted input did not reach stage 1");

  // Back-pressure reaches the input only when every stage is full and stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && s2_vld_r && s3_vld_r && out_vld_r && !out_tready))
    else $error("input stalled with an empty stage");

  // A full middle stage that moves on delivers its item to the next stage
  a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s3_en) |=> s3_vld_r)
    else $error("stage 2 item lost on advance");

  // A stalled final stage holds its item in stage 3 as well
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && !out_en) |=> (s3_vld_r && $stable(s3_n_r) && $stable(s3_sec_r)))
    else $error("stage 3 changed under stall");
`endif

endmodule
